@@ rtl/lpm_pkg.sv @@
// ----------------------------------------------------------------------------
// lpm_pkg
// Shared constants and types for the binary trie longest prefix match unit.
// ----------------------------------------------------------------------------
package lpm_pkg;

  localparam int NODE_COUNT_DEF = 1024;
  localparam int ADDR_BITS_DEF  = 32;

  localparam int HOP_W    = 8;
  localparam int LEN_W    = 6;
  localparam int STATUS_W = 2;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_MATCH  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_POOL_FULL = 2'd2;

  // one address bit per trie level from the serial shifter
  typedef struct packed {
    logic bit_val;
    logic at_end;
  } walk_t;

endpackage

@@ rtl/lpm_ram.sv @@
// ----------------------------------------------------------------------------
// lpm_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module lpm_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/lpm_bit_shift.sv @@
// ----------------------------------------------------------------------------
// lpm_bit_shift
// Serial address shifter: hands out one address bit per trie level, most
// significant first, and flags the level at which the walk must stop.
// ----------------------------------------------------------------------------
module lpm_bit_shift #(
  parameter int ADDR_BITS = lpm_pkg::ADDR_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        load,
  input  logic                        step,
  input  logic                        cmd,
  input  logic [ADDR_BITS-1:0]        address,
  input  logic [lpm_pkg::LEN_W-1:0]   prefix_len,
  output lpm_pkg::walk_t              walk
);

  localparam int LVL_W = $clog2(ADDR_BITS + 1);

  logic [ADDR_BITS-1:0] shift_reg;
  logic [LVL_W-1:0]     level;
  logic [LVL_W-1:0]     limit;
  logic [LVL_W-1:0]     limit_next;

  // overlong prefixes saturate to the full address width
  always_comb begin
    if (cmd == lpm_pkg::CMD_LOOKUP) begin
      limit_next = LVL_W'(ADDR_BITS);
    end else if ({1'b0, prefix_len} > 7'(ADDR_BITS)) begin
      limit_next = LVL_W'(ADDR_BITS);
    end else begin
      limit_next = LVL_W'(prefix_len);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      shift_reg <= address;
      level     <= '0;
      limit     <= limit_next;
    end else if (step) begin
      shift_reg <= shift_reg << 1;
      level     <= level + LVL_W'(1);
    end
  end

  assign walk.bit_val = shift_reg[ADDR_BITS-1];
  assign walk.at_end  = (level == limit);

endmodule

@@ rtl/binary_trie_longest_prefix_match_unit.sv @@
// ----------------------------------------------------------------------------
// binary_trie_longest_prefix_match_unit
// Longest prefix match table kept as a one-bit-per-level trie in a node RAM.
// ----------------------------------------------------------------------------
// channel   signals                                   handshake
// input     cmd, address, prefix_len, next_hop        start & !busy
// result    status, hop_out                           done (one cycle)
//
// A walk takes one trie level per cycle through the node RAM's registered
// read port: an add walks to its prefix length or until the pool is full, a
// lookup until the address or its path ends. The result strobe follows in
// the next cycle, with busy already low; the next item may start with it.
// Synchronous reset empties the trie at once: root cleared, pool count zero.
// The receiver cannot stall; done lasts exactly one cycle.
// ----------------------------------------------------------------------------
module binary_trie_longest_prefix_match_unit #(
  parameter int NODE_COUNT = lpm_pkg::NODE_COUNT_DEF,
  parameter int ADDR_BITS  = lpm_pkg::ADDR_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cmd,
  input  logic [ADDR_BITS-1:0]          address,
  input  logic [lpm_pkg::LEN_W-1:0]     prefix_len,
  input  logic [lpm_pkg::HOP_W-1:0]     next_hop,
  output logic                          done,
  output logic [lpm_pkg::STATUS_W-1:0]  status,
  output logic [lpm_pkg::HOP_W-1:0]     hop_out
);

  localparam int IDX_W  = $clog2(NODE_COUNT);
  localparam int HOP_W  = lpm_pkg::HOP_W;
  localparam int NODE_W = 2 * IDX_W + HOP_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WALK = 1'b1;

  logic                            state;
  logic                            cmd_q;
  logic [HOP_W-1:0]                hop_q;
  logic [IDX_W-1:0]                cur_idx;
  logic                            use_rdata;
  logic [NODE_W-1:0]               node_buf;
  logic [NODE_W-1:0]               root_node;
  logic [HOP_W-1:0]                best_hop;
  logic [IDX_W-1:0]                free_count;

  logic [NODE_W-1:0]               ram_rdata;
  lpm_pkg::walk_t                  walk;

  logic                            accept;
  logic [NODE_W-1:0]               eff;
  logic [HOP_W-1:0]                eff_hop;
  logic [IDX_W-1:0]                left_idx;
  logic [IDX_W-1:0]                right_idx;
  logic [IDX_W-1:0]                child_idx;
  logic [IDX_W-1:0]                new_idx;
  logic                            pool_full;
  logic [HOP_W-1:0]                lookup_hop;
  logic                            finish;
  logic                            descend;
  logic                            alloc;
  logic                            node_wr;
  logic [NODE_W-1:0]               wr_data;
  logic [lpm_pkg::STATUS_W-1:0]    status_next;
  logic [HOP_W-1:0]                hop_out_next;
  logic                            ram_we;
  logic                            root_we;

  assign busy   = (state == S_WALK);
  assign accept = start && !busy;

  // the root lives in flops; other nodes come from the RAM or a fresh node
  always_comb begin
    if (cur_idx == '0) begin
      eff = root_node;
    end else if (use_rdata) begin
      eff = ram_rdata;
    end else begin
      eff = node_buf;
    end
  end

  assign eff_hop    = eff[HOP_W-1:0];
  assign left_idx   = eff[HOP_W +: IDX_W];
  assign right_idx  = eff[HOP_W+IDX_W +: IDX_W];
  assign child_idx  = walk.bit_val ? right_idx : left_idx;
  assign new_idx    = free_count + IDX_W'(1);
  assign pool_full  = (free_count == IDX_W'(NODE_COUNT - 1));
  assign lookup_hop = (eff_hop != '0) ? eff_hop : best_hop;

  always_comb begin
    finish       = 1'b0;
    descend      = 1'b0;
    alloc        = 1'b0;
    node_wr      = 1'b0;
    wr_data      = eff;
    status_next  = lpm_pkg::ST_OK;
    hop_out_next = '0;
    if (state == S_WALK) begin
      if (cmd_q == lpm_pkg::CMD_ADD) begin
        priority if (walk.at_end) begin
          node_wr = 1'b1;
          wr_data = {right_idx, left_idx, hop_q};
          finish  = 1'b1;
        end else if (child_idx != '0) begin
          descend = 1'b1;
        end else if (pool_full) begin
          // a fresh node on the path is flushed unchanged
          node_wr     = 1'b1;
          finish      = 1'b1;
          status_next = lpm_pkg::ST_POOL_FULL;
        end else begin
          alloc   = 1'b1;
          node_wr = 1'b1;
          wr_data = walk.bit_val ? {new_idx, left_idx, eff_hop}
                                 : {right_idx, new_idx, eff_hop};
        end
      end else begin
        if (walk.at_end || child_idx == '0) begin
          finish       = 1'b1;
          status_next  = (lookup_hop == '0) ? lpm_pkg::ST_NO_MATCH : lpm_pkg::ST_OK;
          hop_out_next = lookup_hop;
        end else begin
          descend = 1'b1;
        end
      end
    end
  end

  assign ram_we  = node_wr && (cur_idx != '0);
  assign root_we = node_wr && (cur_idx == '0);

  lpm_bit_shift #(
    .ADDR_BITS (ADDR_BITS)
  ) u_shift (
    .clk        (clk),
    .load       (accept),
    .step       (descend || alloc),
    .cmd        (cmd),
    .address    (address),
    .prefix_len (prefix_len),
    .walk       (walk)
  );

  lpm_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODE_COUNT)
  ) u_nodes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_idx),
    .wdata (wr_data),
    .raddr (child_idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      root_node  <= '0;
      free_count <= '0;
    end else begin
      done <= finish;
      if (accept) begin
        state <= S_WALK;
      end else if (finish) begin
        state <= S_IDLE;
      end
      if (root_we) begin
        root_node <= wr_data;
      end
      if (alloc) begin
        free_count <= new_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q    <= cmd;
      hop_q    <= next_hop;
      cur_idx  <= '0;
      best_hop <= '0;
    end else if (descend) begin
      cur_idx   <= child_idx;
      use_rdata <= 1'b1;
      best_hop  <= lookup_hop;
    end else if (alloc) begin
      cur_idx   <= new_idx;
      use_rdata <= 1'b0;
      node_buf  <= '0;
    end
    if (finish) begin
      status  <= status_next;
      hop_out <= hop_out_next;
    end
  end

endmodule

@@ rtl/lpm_checker.sv @@
// ----------------------------------------------------------------------------
// lpm_checker
// Port-level checks on the prefix match unit's command and result timing.
// ----------------------------------------------------------------------------
module lpm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [lpm_pkg::STATUS_W-1:0]  status,
  input logic [lpm_pkg::HOP_W-1:0]     hop_out
);

  // every accepted item keeps the unit busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // the result comes exactly when the walk ends
  a_done_on_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy fell without a result");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("result outside the end of a walk");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> status == lpm_pkg::ST_OK || status == lpm_pkg::ST_NO_MATCH ||
             status == lpm_pkg::ST_POOL_FULL)
    else $error("unknown status code");

  a_hop_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    done && status != lpm_pkg::ST_OK |-> hop_out == '0)
    else $error("nonzero hop with error status");

endmodule

bind binary_trie_longest_prefix_match_unit lpm_checker u_lpm_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .status  (status),
  .hop_out (hop_out)
);
